FILE: rtl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants of the ANSI text terminal buffer
// Item structs, character codes, register indexes and the power-up screen
// pattern of the 80-cell display memory.
// ----------------------------------------------------------------------------
`default_nettype none

package atb_pkg;

	localparam int MEM_CELLS = 80;
	localparam int ADDR_W    = 7;
	localparam int ROW_W     = 3;
	localparam int COL_W     = 7;
	localparam int CELL_W    = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	localparam logic [ADDR_W-1:0] CELLS_A  = ADDR_W'(MEM_CELLS);
	localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_CELLS - 1);
	localparam logic [CELL_W-1:0] CELLS_C  = CELL_W'(MEM_CELLS);

	// operation codes
	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_LOG2 = 1'b1;

	// character codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ED    = 8'h4A;
	localparam logic [7:0] CH_CUP   = 8'h48;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic              op;
		logic [7:0]        char_in;
		logic [ADDR_W-1:0] read_addr;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
	} out_item_t;

	// power-up screen: digits, lower case, upper case, digits down, z down to s
	function automatic logic [7:0] reset_char(input logic [ADDR_W-1:0] idx);
		logic [7:0] i8;
		i8 = 8'(idx);
		if (idx < 7'd10)
			return 8'(8'h30 + i8);
		else if (idx < 7'd36)
			return 8'(8'h61 + i8 - 8'd10);
		else if (idx < 7'd62)
			return 8'(8'h41 + i8 - 8'd36);
		else if (idx < 7'd72)
			return 8'(8'h39 + 8'd62 - i8);
		else
			return 8'(8'h7A + 8'd72 - i8);
	endfunction

	// decimal accumulate, saturating at 255
	function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] ch);
		logic [11:0] v;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, ch[3:0]};
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ansi_text_terminal_buffer_top.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_buffer_top: byte-stream text terminal over 80 cells
// Parses printable text, newline, ESC[nJ and ESC[n;mH into an 80-cell
// character memory of 1, 2 or 4 rows, and reads single cells back.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (in_valid/in_stall, in_data): op 0 feeds char_in into the
//   parser, op 1 reads the cell at read_addr. Every input beat yields exactly
//   one output beat (out_valid/out_stall, out_data) with the read data (zero
//   for a fed byte) and the cursor after the step.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets columns and
//   rows_log2; write it only while no item is in flight.
//   Reads, plain text, newline and escape bytes go from accept through the
//   finish step to the output register; ESC[nJ first blanks up to 80 cells.
//   A scrolling byte copies 80 - stride cells a row up and drains the last
//   read (rows > 1), blanks stride cells and stores the byte; one cell moves
//   per cycle through the single memory write port and address counter.
//   in_stall is high while an item is being worked; one result may wait in
//   the output register while the next item is accepted. If out_stall holds,
//   the following result waits and the block stays stalled.
//   Reset: cursor home, parser in text mode, 16 columns by 2 rows, and the
//   memory reads as the power-up pattern until each cell is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_text_terminal_buffer_top import atb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COPY  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_STORE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [1:0] PM_TEXT = 2'd0;
	localparam logic [1:0] PM_ESC  = 2'd1;
	localparam logic [1:0] PM_ARG1 = 2'd2;
	localparam logic [1:0] PM_ARG2 = 2'd3;

	// control state
	logic [2:0]        state_q, state_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [1:0]        mode_q, mode_d;
	logic [7:0]        a1_q, a1_d, a2_q, a2_d;
	logic              flag_q, flag_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [ADDR_W-1:0] fill_end_q, fill_end_d;
	logic              fill_store_q, fill_store_d;
	logic              op_q, op_d;
	logic              oob_q, oob_d;
	logic [6:0]        columns_q;
	logic [1:0]        rows_log2_q;
	logic              out_valid_q;
	logic              out_load;

	// payload
	logic [7:0]        char_q;
	out_item_t         out_data_q;

	// memory
	logic [7:0]           mem [0:MEM_CELLS-1];
	logic [MEM_CELLS-1:0] vld_q;
	logic [7:0]           rd_mem_q;
	logic                 rd_vld_q;
	logic [ADDR_W-1:0]    rd_addr_q;
	logic [7:0]           rdata;
	logic                 wr_en, rd_en;
	logic [ADDR_W-1:0]    wr_addr, rd_addr;
	logic [7:0]           wr_dat;

	// geometry
	logic [1:0]        rl_eff;
	logic [ROW_W-1:0]  rows;
	logic [ADDR_W-1:0] stride, keep, cols, cols_a;
	logic [CELL_W-1:0] row80, row_off, cur_cell;

	// parser
	logic [7:0] cur_ch;
	logic       is_digit;
	logic [1:0] pm_mode;
	logic [7:0] pm_a1, pm_a2;
	logic       pm_flag, pm_text, pm_erase, pm_cup;

	// erase span, cursor placement, text store
	logic              er_go;
	logic [ADDR_W-1:0] er_start, er_end;
	logic [CELL_W-1:0] cell_p1;
	logic [7:0]        cup_n, cup_m, cup_r8, cup_c8;
	logic [ROW_W-1:0]  cup_row;
	logic [COL_W-1:0]  cup_col;
	logic              st_wr;
	logic [ADDR_W-1:0] st_addr;
	logic [COL_W:0]    col_inc;
	logic [ROW_W-1:0]  st_row_n;
	logic [COL_W-1:0]  st_col_n;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// geometry from the registers
	always_comb begin
		rl_eff = (rows_log2_q > 2'd2) ? 2'd2 : rows_log2_q;
		unique case (rl_eff)
			2'd0: begin
				rows   = 3'd1;
				stride = 7'd80;
			end
			2'd1: begin
				rows   = 3'd2;
				stride = 7'd40;
			end
			default: begin
				rows   = 3'd4;
				stride = 7'd20;
			end
		endcase
		keep   = 7'(CELLS_A - stride);
		cols_a = (columns_q == 7'd0) ? 7'd1 : columns_q;
		cols   = (cols_a > stride) ? stride : cols_a;
		row80  = (CELL_W'(row_q) << 6) + (CELL_W'(row_q) << 4);
		row_off = row80 >> rl_eff;
		cur_cell = CELL_W'(col_q) + row_off;
	end

	// escape sequence parser
	always_comb begin
		cur_ch   = in_data.char_in;
		is_digit = (cur_ch >= CH_ZERO) && (cur_ch <= CH_NINE);
		pm_mode  = mode_q;
		pm_a1    = a1_q;
		pm_a2    = a2_q;
		pm_flag  = flag_q;
		pm_text  = 1'b0;
		pm_erase = 1'b0;
		pm_cup   = 1'b0;
		unique case (mode_q)
			PM_ESC: begin
				if (cur_ch == CH_LBRK) begin
					pm_a1   = 8'd0;
					pm_a2   = 8'd0;
					pm_flag = 1'b1;
					pm_mode = PM_ARG1;
				end else begin
					pm_mode = PM_TEXT;
					pm_text = 1'b1;
				end
			end
			PM_ARG1: begin
				// empty first argument before ';' counts as one
				if (flag_q && cur_ch == CH_SEMI)
					pm_a1 = 8'd1;
				pm_flag = 1'b0;
				if (is_digit) begin
					pm_a1 = add_digit(a1_q, cur_ch);
				end else if (cur_ch == CH_SEMI) begin
					pm_flag = 1'b1;
					pm_mode = PM_ARG2;
				end else if (cur_ch == CH_ED) begin
					pm_erase = 1'b1;
					pm_mode  = PM_TEXT;
				end else begin
					pm_mode = PM_TEXT;
					pm_text = 1'b1;
				end
			end
			PM_ARG2: begin
				if (flag_q && !is_digit)
					pm_a2 = 8'd1;
				pm_flag = 1'b0;
				if (is_digit) begin
					pm_a2 = add_digit(a2_q, cur_ch);
				end else if (cur_ch == CH_CUP) begin
					pm_cup  = 1'b1;
					pm_mode = PM_TEXT;
				end else begin
					pm_mode = PM_TEXT;
					pm_text = 1'b1;
				end
			end
			default: begin
				pm_text = 1'b1;
			end
		endcase
	end

	// erase span, cursor placement and text store arithmetic
	always_comb begin
		cell_p1  = cur_cell + 10'd1;
		er_go    = 1'b0;
		er_start = 7'd0;
		er_end   = CELLS_A;
		case (pm_a1)
			8'd0: begin
				er_go    = (cur_cell < CELLS_C);
				er_start = cur_cell[ADDR_W-1:0];
			end
			8'd1: begin
				er_go  = 1'b1;
				er_end = (cell_p1 >= CELLS_C) ? CELLS_A : cell_p1[ADDR_W-1:0];
			end
			8'd2: begin
				er_go = 1'b1;
			end
			default: begin
				er_go = 1'b0;
			end
		endcase

		cup_n  = (pm_a1 == 8'd0) ? 8'd1 : pm_a1;
		cup_m  = (pm_a2 == 8'd0) ? 8'd1 : pm_a2;
		cup_r8 = cup_n - 8'd1;
		cup_c8 = cup_m - 8'd1;
		cup_row = (cup_r8 >= 8'(rows)) ? 3'(rows - 3'd1) : cup_r8[ROW_W-1:0];
		cup_col = (cup_c8 >= 8'(cols)) ? 7'(cols - 7'd1) : cup_c8[COL_W-1:0];

		st_wr   = (cur_cell < CELLS_C);
		st_addr = cur_cell[ADDR_W-1:0];
		col_inc = 8'(col_q) + 8'd1;
		if (col_inc >= 8'(cols)) begin
			st_col_n = 7'd0;
			st_row_n = 3'(row_q + 3'd1);
		end else begin
			st_col_n = col_inc[COL_W-1:0];
			st_row_n = row_q;
		end
	end

	// sequencer
	always_comb begin
		state_d      = state_q;
		row_d        = row_q;
		col_d        = col_q;
		mode_d       = mode_q;
		a1_d         = a1_q;
		a2_d         = a2_q;
		flag_d       = flag_q;
		ptr_d        = ptr_q;
		fill_end_d   = fill_end_q;
		fill_store_d = fill_store_q;
		op_d         = op_q;
		oob_d        = oob_q;
		wr_en        = 1'b0;
		wr_addr      = ptr_q;
		wr_dat       = CH_SPACE;
		rd_en        = 1'b0;
		rd_addr      = ptr_q;
		out_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = in_data.op;
					oob_d   = (in_data.read_addr >= CELLS_A);
					state_d = S_FIN;
					if (in_data.op == OP_READ) begin
						rd_en   = 1'b1;
						rd_addr = oob_d ? 7'd0 : in_data.read_addr;
					end else begin
						mode_d = pm_mode;
						a1_d   = pm_a1;
						a2_d   = pm_a2;
						flag_d = pm_flag;
						if (pm_text) begin
							if (cur_ch == CH_ESC) begin
								mode_d = PM_ESC;
							end else if (cur_ch == CH_NL) begin
								row_d = (row_q < rows) ? 3'(row_q + 3'd1) : rows;
								col_d = 7'd0;
							end else if (row_q >= rows) begin
								// scroll pending: shift rows up if more than one, blank the last, then store
								row_d = 3'(rows - 3'd1);
								if (rl_eff == 2'd0) begin
									ptr_d        = 7'd0;
									fill_end_d   = CELLS_A;
									fill_store_d = 1'b1;
									state_d      = S_FILL;
								end else begin
									ptr_d   = stride;
									state_d = S_COPY;
								end
							end else begin
								wr_en   = st_wr;
								wr_addr = st_addr;
								wr_dat  = cur_ch;
								row_d   = st_row_n;
								col_d   = st_col_n;
							end
						end else if (pm_erase) begin
							if (er_go) begin
								ptr_d        = er_start;
								fill_end_d   = er_end;
								fill_store_d = 1'b0;
								state_d      = S_FILL;
							end
						end else if (pm_cup) begin
							row_d = cup_row;
							col_d = cup_col;
						end
					end
				end
			end
			S_COPY: begin
				// read one cell ahead, write the previous one a row up
				rd_en   = 1'b1;
				rd_addr = ptr_q;
				ptr_d   = 7'(ptr_q + 7'd1);
				if (ptr_q != stride) begin
					wr_en   = 1'b1;
					wr_addr = 7'(rd_addr_q - stride);
					wr_dat  = rdata;
				end
				if (ptr_q == MEM_LAST)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				wr_en        = 1'b1;
				wr_addr      = 7'(rd_addr_q - stride);
				wr_dat       = rdata;
				ptr_d        = keep;
				fill_end_d   = CELLS_A;
				fill_store_d = 1'b1;
				state_d      = S_FILL;
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				wr_dat  = CH_SPACE;
				ptr_d   = 7'(ptr_q + 7'd1);
				if (7'(ptr_q + 7'd1) == fill_end_q)
					state_d = fill_store_q ? S_STORE : S_FIN;
			end
			S_STORE: begin
				wr_en   = st_wr;
				wr_addr = st_addr;
				wr_dat  = char_q;
				row_d   = st_row_n;
				col_d   = st_col_n;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_q        <= '0;
			col_q        <= '0;
			mode_q       <= PM_TEXT;
			a1_q         <= '0;
			a2_q         <= '0;
			flag_q       <= 1'b0;
			ptr_q        <= '0;
			fill_end_q   <= '0;
			fill_store_q <= 1'b0;
			op_q         <= OP_FEED;
			oob_q        <= 1'b0;
			columns_q    <= 7'd16;
			rows_log2_q  <= 2'd1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			row_q        <= row_d;
			col_q        <= col_d;
			mode_q       <= mode_d;
			a1_q         <= a1_d;
			a2_q         <= a2_d;
			flag_q       <= flag_d;
			ptr_q        <= ptr_d;
			fill_end_q   <= fill_end_d;
			fill_store_q <= fill_store_d;
			op_q         <= op_d;
			oob_q        <= oob_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_COLUMNS:   columns_q   <= cfg_data[6:0];
					REG_ROWS_LOG2: rows_log2_q <= cfg_data[1:0];
					default:       columns_q   <= columns_q;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			char_q <= in_data.char_in;
		if (out_load) begin
			out_data_q.read_data  <= (op_q == OP_READ && !oob_q) ? rdata : 8'd0;
			out_data_q.cursor_row <= row_q;
			out_data_q.cursor_col <= col_q;
		end
	end

	// display memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_dat;
		if (rd_en) begin
			rd_mem_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// a cell never written reads as the power-up pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rdata = rd_vld_q ? rd_mem_q : reset_char(rd_addr_q);

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr < CELLS_A))
		else $error("memory write beyond the last cell");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= 3'd4)
		else $error("cursor row beyond scroll-pending position");

	a_fill_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (ptr_q < fill_end_q))
		else $error("blank fill pointer past its end");

	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (ptr_q >= stride))
		else $error("scroll copy source above the second row");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("result beat raised outside the finish step");

endmodule

`default_nettype wire
